### sv/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; imported by median_filter_3x3_unit.
`default_nettype none

package mf3_pkg;

    localparam logic [12:0] ROW_CNT_RESET = 13'd480;
    localparam logic [12:0] ROW_CNT_LIMIT = 13'd4096;
    localparam logic [11:0] COL_CNT_RESET = 12'd640;
    localparam logic [11:0] COL_CNT_CAP   = 12'd2048;

    localparam int unsigned NUM_SLOTS = 4;
    localparam int unsigned NUM_TAPS  = 9;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef logic [15:0] t_sample;

    // red in the low bits, blue in the high bits
    typedef struct packed {
        t_sample blue;
        t_sample green;
        t_sample red;
    } t_pixel;

    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] median_red;
        logic [15:0] median_green;
        logic [15:0] median_blue;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        was_filtered;
        logic        last_of_run;
    } t_out_beat;

    typedef struct packed {
        t_pixel      pix;
        logic [11:0] row;
        logic [10:0] col;
        logic        filt;
    } t_slot;

    typedef struct packed {
        t_pixel upper;
        t_pixel lower;
    } t_line_entry;

    typedef struct packed {
        t_sample lo;
        t_sample md;
        t_sample hi;
    } t_triple;

    function automatic t_sample pix_chan(input t_pixel p, input logic [1:0] ch);
        t_sample s;
        unique case (ch)
            2'd0:    s = p.red;
            2'd1:    s = p.green;
            default: s = p.blue;
        endcase
        return s;
    endfunction

    function automatic t_triple sort3(input t_sample a, input t_sample b, input t_sample c);
        t_sample l0;
        t_sample h0;
        t_sample l1;
        t_triple t;
        l0   = (a < b) ? a : b;
        h0   = (a < b) ? b : a;
        l1   = (h0 < c) ? h0 : c;
        t.hi = (h0 < c) ? c : h0;
        t.lo = (l0 < l1) ? l0 : l1;
        t.md = (l0 < l1) ? l1 : l0;
        return t;
    endfunction

    function automatic t_sample max3(input t_sample a, input t_sample b, input t_sample c);
        t_sample m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic t_sample min3(input t_sample a, input t_sample b, input t_sample c);
        t_sample m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_sample med3(input t_sample a, input t_sample b, input t_sample c);
        t_sample lo;
        t_sample hi;
        t_sample m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

`default_nettype wire

### sv/median_filter_3x3_unit.sv
// Streaming 3x3 median filter, three channels, raster order in and out.
// Depends on mf3_pkg (beat types, median compare helpers).
//
//  channel   dir  handshake                    payload
//  -------   ---  ---------------------------  --------------------------
//  in        in   i_in_valid / o_in_stall      i_in_beat  (t_in_beat)
//  out       out  o_out_valid / i_out_stall    o_out_beat (t_out_beat)
//  config    in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One input beat per clock unless o_in_stall. Each beat yields 0 to 4 result
// beats; the output sequencer sends one per clock unless i_out_stall, so a
// beat with several results can hold the input. A result passes the window
// stage, three median stages, the sequencer and the output register. Line
// memory is not cleared after reset; row 0 masks its read data, row 1 its
// upper half. A stalled output backs up through the pipeline into o_in_stall.
`default_nettype none

module median_filter_3x3_unit #(
    parameter int unsigned MAX_COLS = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mf3_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mf3_pkg::t_out_beat  o_out_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mf3_pkg::*;

    localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [11:0] COL_LIMIT =
        (MAX_COLS < int'(COL_CNT_CAP)) ? 12'(MAX_COLS) : COL_CNT_CAP;

    // ---------------- configuration ----------------
    logic [12:0] r_row_count;
    logic [11:0] r_col_count;
    logic        cfg_wr;
    logic [12:0] row_lim;
    logic [11:0] col_lim;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_CNT_RESET;
            r_col_count <= COL_CNT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROW_COUNT) begin
                r_row_count <= pwdata[12:0];
            end else begin
                r_col_count <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLUMN_COUNT) ? {20'd0, r_col_count}
                                                   : {19'd0, r_row_count};

    always_comb begin
        if (r_row_count == 13'd0) begin
            row_lim = 13'd1;
        end else if (r_row_count > ROW_CNT_LIMIT) begin
            row_lim = ROW_CNT_LIMIT;
        end else begin
            row_lim = r_row_count;
        end
        if (r_col_count == 12'd0) begin
            col_lim = 12'd1;
        end else if (r_col_count > COL_LIMIT) begin
            col_lim = COL_LIMIT;
        end else begin
            col_lim = r_col_count;
        end
    end

    // ---------------- flow control ----------------
    logic in_accept;
    logic s1_free, s1_move;
    logic s2_free, s3_free, s4_free, s4_move;
    logic seq_free, seq_emit, seq_last, out_load;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_out_valid;
    logic [NUM_SLOTS-1:0] r_seq_mask;

    assign out_load  = !r_out_valid || !i_out_stall;
    assign seq_emit  = (r_seq_mask != '0) && out_load;
    assign seq_free  = (r_seq_mask == '0) || (out_load && seq_last);
    assign s4_free   = !r_s4_valid || seq_free;
    assign s4_move   = r_s4_valid && seq_free;
    assign s3_free   = !r_s3_valid || s4_free;
    assign s2_free   = !r_s2_valid || s3_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign s1_move   = r_s1_valid && s2_free;
    assign in_accept = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // ---------------- position counters ----------------
    logic [11:0] r_row;
    logic [10:0] r_col;
    logic        col_end_in, row_end_in;

    assign col_end_in = ({1'b0, r_col} + 12'd1) >= col_lim;
    assign row_end_in = ({1'b0, r_row} + 13'd1) >= row_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            if (col_end_in) begin
                r_col <= '0;
                r_row <= row_end_in ? 12'd0 : (r_row + 12'd1);
            end else begin
                r_col <= r_col + 11'd1;
            end
        end
    end

    // ---------------- line memory ----------------
    // entry c holds {row r-2, row r-1} of column c; read on accept, written
    // back from the window stage when it moves on
    t_line_entry     r_line_mem [MAX_COLS];
    t_line_entry     r_rd_data;
    t_line_entry     r_fwd_data;
    logic            r_fwd_hit;
    t_line_entry     wr_entry;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   r_s1_addr;

    assign rd_addr = AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_line_mem[rd_addr];
        end
        if (s1_move) begin
            r_line_mem[r_s1_addr] <= wr_entry;
        end
    end

    // same column read and written in one cycle (one-column frame)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_accept) begin
            r_fwd_hit <= s1_move && (r_s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= wr_entry;
        end
    end

    // ---------------- S1: window stage ----------------
    t_pixel      r_s1_pix;
    logic [11:0] r_s1_row;
    logic [10:0] r_s1_col;
    logic        r_s1_col_end, r_s1_row_end;
    t_pixel      r_win [6];

    t_line_entry line_q;
    t_pixel      top, mid, cur;
    logic        row_ge1, row_ge2, col_ge1, col_ge2, interior;
    logic [10:0] col_last;
    t_slot       s1_slots [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] s1_mask;
    t_pixel      s1_taps [NUM_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix.red   <= i_in_beat.sample_red;
            r_s1_pix.green <= i_in_beat.sample_green;
            r_s1_pix.blue  <= i_in_beat.sample_blue;
            r_s1_row       <= r_row;
            r_s1_col       <= r_col;
            r_s1_col_end   <= col_end_in;
            r_s1_row_end   <= row_end_in;
            r_s1_addr      <= rd_addr;
        end
    end

    always_comb begin
        line_q   = r_fwd_hit ? r_fwd_data : r_rd_data;
        cur      = r_s1_pix;
        row_ge1  = r_s1_row != 12'd0;
        row_ge2  = r_s1_row > 12'd1;
        col_ge1  = r_s1_col != 11'd0;
        col_ge2  = r_s1_col > 11'd1;
        top      = row_ge2 ? line_q.upper : '0;
        mid      = row_ge1 ? line_q.lower : '0;
        interior = row_ge2 && col_ge2
                && (({1'b0, r_s1_row} + 13'd1) <= row_lim)
                && (({1'b0, r_s1_col} + 12'd1) <= col_lim);
        col_last = 11'(col_lim - 12'd1);

        wr_entry.upper = mid;
        wr_entry.lower = cur;

        // emit order: window center, row-end of row r-1, last-row pixels
        s1_slots[0].pix  = r_win[1];
        s1_slots[0].row  = r_s1_row - 12'd1;
        s1_slots[0].col  = r_s1_col - 11'd1;
        s1_slots[0].filt = interior;
        s1_slots[1].pix  = mid;
        s1_slots[1].row  = r_s1_row - 12'd1;
        s1_slots[1].col  = col_last;
        s1_slots[1].filt = 1'b0;
        s1_slots[2].pix  = r_win[2];
        s1_slots[2].row  = r_s1_row;
        s1_slots[2].col  = r_s1_col - 11'd1;
        s1_slots[2].filt = 1'b0;
        s1_slots[3].pix  = cur;
        s1_slots[3].row  = r_s1_row;
        s1_slots[3].col  = col_last;
        s1_slots[3].filt = 1'b0;

        s1_mask[0] = row_ge1 && col_ge1;
        s1_mask[1] = row_ge1 && r_s1_col_end;
        s1_mask[2] = r_s1_row_end && col_ge1;
        s1_mask[3] = r_s1_row_end && r_s1_col_end;

        s1_taps[0] = r_win[3];
        s1_taps[1] = r_win[0];
        s1_taps[2] = top;
        s1_taps[3] = r_win[4];
        s1_taps[4] = r_win[1];
        s1_taps[5] = mid;
        s1_taps[6] = r_win[5];
        s1_taps[7] = r_win[2];
        s1_taps[8] = cur;
    end

    // window columns: 0..2 column c-1, 3..5 column c-2, top to bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_move) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top;
            r_win[1] <= mid;
            r_win[2] <= cur;
        end
    end

    // ---------------- S2: row sort ----------------
    t_pixel               r_s2_taps  [NUM_TAPS];
    t_slot                r_s2_slots [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_s2_mask;
    t_triple              s2_sorted [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_move && (s1_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_taps  <= s1_taps;
            r_s2_slots <= s1_slots;
            r_s2_mask  <= s1_mask;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
                s2_sorted[ch][k] = sort3(pix_chan(r_s2_taps[3*k],     2'(ch)),
                                         pix_chan(r_s2_taps[3*k + 1], 2'(ch)),
                                         pix_chan(r_s2_taps[3*k + 2], 2'(ch)));
            end
        end
    end

    // ---------------- S3: max of lows, median of mids, min of highs ----------------
    t_triple              r_s3_sorted [3][3];
    t_slot                r_s3_slots  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_s3_mask;
    t_sample              s3_cand [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            r_s3_sorted <= s2_sorted;
            r_s3_slots  <= r_s2_slots;
            r_s3_mask   <= r_s2_mask;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s3_cand[ch][0] = max3(r_s3_sorted[ch][0].lo, r_s3_sorted[ch][1].lo,
                                  r_s3_sorted[ch][2].lo);
            s3_cand[ch][1] = med3(r_s3_sorted[ch][0].md, r_s3_sorted[ch][1].md,
                                  r_s3_sorted[ch][2].md);
            s3_cand[ch][2] = min3(r_s3_sorted[ch][0].hi, r_s3_sorted[ch][1].hi,
                                  r_s3_sorted[ch][2].hi);
        end
    end

    // ---------------- S4: final median of three ----------------
    t_sample              r_s4_cand  [3][3];
    t_slot                r_s4_slots [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_s4_mask;
    t_pixel               med_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_free) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_free && r_s3_valid) begin
            r_s4_cand  <= s3_cand;
            r_s4_slots <= r_s3_slots;
            r_s4_mask  <= r_s3_mask;
        end
    end

    assign med_pix.red   = med3(r_s4_cand[0][0], r_s4_cand[0][1], r_s4_cand[0][2]);
    assign med_pix.green = med3(r_s4_cand[1][0], r_s4_cand[1][1], r_s4_cand[1][2]);
    assign med_pix.blue  = med3(r_s4_cand[2][0], r_s4_cand[2][1], r_s4_cand[2][2]);

    // ---------------- output sequencer ----------------
    t_slot                r_seq_slots [NUM_SLOTS];
    t_slot                seq_load    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] seq_low, seq_rest;
    logic [1:0]           seq_idx;
    t_slot                seq_slot;
    t_out_beat            r_out;

    assign seq_low  = r_seq_mask & (~r_seq_mask + 4'd1);
    assign seq_rest = r_seq_mask & ~seq_low;
    assign seq_last = seq_rest == '0;

    always_comb begin
        priority if (r_seq_mask[0]) begin
            seq_idx = 2'd0;
        end else if (r_seq_mask[1]) begin
            seq_idx = 2'd1;
        end else if (r_seq_mask[2]) begin
            seq_idx = 2'd2;
        end else begin
            seq_idx = 2'd3;
        end
        seq_slot = r_seq_slots[seq_idx];
    end

    // interior center pixel takes the median in place of the raw sample
    always_comb begin
        seq_load = r_s4_slots;
        if (r_s4_slots[0].filt) begin
            seq_load[0].pix = med_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_mask <= '0;
        end else if (s4_move) begin
            r_seq_mask <= r_s4_mask;
        end else if (seq_emit) begin
            r_seq_mask <= seq_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_move) begin
            r_seq_slots <= seq_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= seq_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_emit) begin
            r_out.median_red   <= seq_slot.pix.red;
            r_out.median_green <= seq_slot.pix.green;
            r_out.median_blue  <= seq_slot.pix.blue;
            r_out.out_row      <= seq_slot.row;
            r_out.out_col      <= seq_slot.col;
            r_out.was_filtered <= seq_slot.filt;
            r_out.last_of_run  <= seq_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // ---------------- assertions ----------------
    a_filt_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.was_filtered |-> r_out.out_row != 12'd0 && r_out.out_col != 11'd0)
        else $error("filtered beat on a border row or column");

    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_of_run |-> r_seq_mask != '0)
        else $error("non-final beat sent with nothing left in the sequencer");

    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && r_seq_mask != '0 |=> $stable(r_seq_mask))
        else $error("sequencer advanced while output stalled");

    a_s4_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> r_s4_mask != '0)
        else $error("empty result set reached the median stage");

    a_s1_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with empty window stage");

endmodule

`default_nettype wire
